[rtl/core/gbt_pkg.sv]
package gbt_pkg;

    // field widths fixed by the item format
    localparam int VTX_W = 5;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 6'd32;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_BFS   = 2'd2,
        FUNC_DFS   = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]       func;
        logic [VTX_W-1:0] edge_from;
        logic [VTX_W-1:0] edge_to;
        logic [VTX_W-1:0] start_node;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
    } t_out_item;

    // classified command from front to back
    typedef struct packed {
        t_func            op;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_ch;

    // result transfer from back to result queue
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res;

endpackage

[rtl/core/gbt_front.sv]
module gbt_front #(
    parameter int MAX_NODES = 32,
    parameter int CW        = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gbt_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_cfg_valid,
    input  logic [5:0]        i_cfg_data,
    output logic [CW-1:0]     o_node_eff,
    output gbt_pkg::t_cmd_ch  o_cmd,
    input  logic              i_cmd_pop
);
    import gbt_pkg::*;

    logic [CNT_W-1:0] r_node_count;
    t_cmd             r_q [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             keep;
    logic             acc;
    t_cmd             cmd_in;

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_node_count <= i_cfg_data;
        end
    end

    // effective count, clamped to the matrix size
    always_comb begin
        if (r_node_count > MAX_NODES) begin
            o_node_eff = CW'(MAX_NODES);
        end else begin
            o_node_eff = CW'(r_node_count);
        end
    end

    // classify: drop edges and starts that lie outside the graph
    always_comb begin
        cmd_in.op = t_func'(i_item.func);
        cmd_in.a  = i_item.edge_from;
        cmd_in.b  = i_item.edge_to;
        keep      = 1'b1;
        unique case (t_func'(i_item.func))
            FUNC_CLEAR: keep = 1'b1;
            FUNC_ADD: begin
                keep = ({2'b00, i_item.edge_from} < 7'(o_node_eff)) &&
                       ({2'b00, i_item.edge_to} < 7'(o_node_eff));
            end
            FUNC_BFS, FUNC_DFS: begin
                cmd_in.a = i_item.start_node;
                keep     = {2'b00, i_item.start_node} < 7'(o_node_eff);
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_full = (r_cnt == 2'd2);
    assign acc    = i_push && !o_full && keep;

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(i_cmd_pop);
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.cmd   = r_q[r_rd];

endmodule

[rtl/core/gbt_back.sv]
module gbt_back #(
    parameter int MAX_NODES = 32,
    parameter int VW        = 5,
    parameter int CW        = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CW-1:0]    i_node_eff,
    input  gbt_pkg::t_cmd_ch i_cmd,
    output logic             o_cmd_pop,
    output gbt_pkg::t_res    o_res,
    input  logic             i_res_full
);
    import gbt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ADD_WR = 7'b0000010,
        ST_POP    = 7'b0000100,
        ST_ROW    = 7'b0001000,
        ST_NB     = 7'b0010000,
        ST_PUSH   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [MAX_NODES-1:0]  r_adj [MAX_NODES];
    logic [MAX_NODES-1:0]  r_row_ok;
    logic [MAX_NODES-1:0]  r_adj_rd;
    logic                  r_adj_ok;
    logic [VW-1:0]         r_ws [MAX_NODES];
    logic [VW-1:0]         r_ws_rd;
    logic [MAX_NODES-1:0]  r_visited;
    logic [MAX_NODES-1:0]  r_nb;
    logic [CW-1:0]         r_rp;
    logic [CW-1:0]         r_wp;
    logic [VW-1:0]         r_a;
    logic [VW-1:0]         r_b;
    logic [VW-1:0]         r_cur;
    logic                  r_dfs;

    logic [VW-1:0]         adj_addr;
    logic [VW-1:0]         ws_raddr;
    logic [VW-1:0]         ws_waddr;
    logic [VW-1:0]         ws_wdata;
    logic                  ws_we;
    logic [MAX_NODES-1:0]  live;
    logic [MAX_NODES-1:0]  row;
    logic [VW-1:0]         pick_lo;
    logic [VW-1:0]         pick_hi;
    logic [VW-1:0]         pick;
    logic                  done;

    // vertices in use
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            live[i] = (i < i_node_eff);
        end
    end

    // lowest and highest pending neighbour
    always_comb begin
        pick_lo = '0;
        pick_hi = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_nb[i]) begin
                pick_lo = VW'(i);
            end
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            if (r_nb[i]) begin
                pick_hi = VW'(i);
            end
        end
        pick = r_dfs ? pick_hi : pick_lo;
    end

    assign row  = r_adj_ok ? r_adj_rd : '0;
    assign done = r_dfs ? (r_wp == '0) : (r_rp == r_wp);

    // memory addressing
    always_comb begin
        adj_addr = (r_state == ST_ROW) ? r_ws_rd : VW'(i_cmd.cmd.a);
        ws_raddr = r_dfs ? VW'(r_wp - 1'b1) : VW'(r_rp);
        ws_we    = 1'b0;
        ws_waddr = VW'(r_wp);
        ws_wdata = pick;
        if (r_state == ST_IDLE) begin
            ws_we    = i_cmd.valid &&
                       (i_cmd.cmd.op == FUNC_BFS || i_cmd.cmd.op == FUNC_DFS);
            ws_waddr = '0;
            ws_wdata = VW'(i_cmd.cmd.a);
        end else if (r_state == ST_PUSH) begin
            ws_we = (r_nb != '0);
        end
    end

    // adjacency memory
    always_ff @(posedge i_clk) begin
        r_adj_rd <= r_adj[adj_addr];
        if (r_state == ST_ADD_WR) begin
            r_adj[r_a] <= row | (MAX_NODES'(1) << r_b);
        end
    end

    // work store: queue for bfs, stack for dfs
    always_ff @(posedge i_clk) begin
        r_ws_rd <= r_ws[ws_raddr];
        if (ws_we) begin
            r_ws[ws_waddr] <= ws_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_adj_ok <= r_row_ok[adj_addr];
        if (r_state == ST_IDLE) begin
            r_a <= VW'(i_cmd.cmd.a);
            r_b <= VW'(i_cmd.cmd.b);
        end
        if (r_state == ST_ROW) begin
            r_cur <= r_ws_rd;
        end
        if (r_state == ST_NB) begin
            r_nb <= row & live & ~r_visited;
        end else if (r_state == ST_PUSH && r_nb != '0) begin
            r_nb[pick] <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_ok  <= '0;
            r_visited <= '0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_dfs     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        unique case (i_cmd.cmd.op)
                            FUNC_CLEAR: r_row_ok <= '0;
                            FUNC_ADD:   r_state <= ST_ADD_WR;
                            FUNC_BFS, FUNC_DFS: begin
                                r_dfs     <= (i_cmd.cmd.op == FUNC_DFS);
                                r_visited <= MAX_NODES'(1) << VW'(i_cmd.cmd.a);
                                r_rp      <= '0;
                                r_wp      <= CW'(1);
                                r_state   <= ST_POP;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ADD_WR: begin
                    r_row_ok[r_a] <= 1'b1;
                    r_state       <= ST_IDLE;
                end
                ST_POP: begin
                    if (r_dfs) begin
                        r_wp <= r_wp - 1'b1;
                    end else begin
                        r_rp <= r_rp + 1'b1;
                    end
                    r_state <= ST_ROW;
                end
                ST_ROW: r_state <= ST_NB;
                ST_NB: begin
                    r_visited <= r_visited | (row & live);
                    r_state   <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (r_nb != '0) begin
                        r_wp <= r_wp + 1'b1;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!i_res_full) begin
                        if (done) begin
                            r_visited <= '0;
                            r_rp      <= '0;
                            r_wp      <= '0;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cmd_pop        = (r_state == ST_IDLE) && i_cmd.valid;
    assign o_res.valid      = (r_state == ST_EMIT) && !i_res_full;
    assign o_res.item.vertex = VTX_W'(r_cur);
    assign o_res.item.last  = done;

endmodule

[rtl/core/gbt_outq.sv]
module gbt_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbt_pkg::t_res       i_res,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output gbt_pkg::t_out_item  o_item
);
    import gbt_pkg::*;

    t_out_item  r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       take;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign take    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_mem[r_wr] <= i_res.item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_res.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (take) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + 3'(i_res.valid) - 3'(take);
        end
    end

endmodule

[rtl/core/graph_bfs_dfs_traversal_core.sv]
// Directed-graph traversal engine. Commands enter through a queue-style push
// port and are checked against the node count register (edges or starts at or
// above it are dropped at once); a two-entry command queue feeds a sequencer
// that owns the adjacency memory and the work store. Clear completes in the
// idle state and an edge add is a read-modify-write of one adjacency row. A
// traversal opens with a start step, and then each visited vertex costs a
// work-store read, an adjacency-row read, a neighbour update, a closing push
// check and a result transfer, which waits while the result queue is full,
// and each pushed neighbour costs a push step. Results (vertex, last) wait in
// a four-entry queue; pop them while empty is low.
module graph_bfs_dfs_traversal_core #(
    parameter int MAX_NODES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  gbt_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output gbt_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data
);
    import gbt_pkg::*;

    localparam int VW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [CW-1:0] node_eff;
    t_cmd_ch       cmd_ch;
    logic          cmd_pop;
    t_res          res;
    logic          res_full;

    assign o_cfg_ready = 1'b1;

    // front: accept and classify
    gbt_front #(
        .MAX_NODES (MAX_NODES),
        .CW        (CW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_node_eff  (node_eff),
        .o_cmd       (cmd_ch),
        .i_cmd_pop   (cmd_pop)
    );

    // back: graph memory and traversal sequencer
    gbt_back #(
        .MAX_NODES (MAX_NODES),
        .VW        (VW),
        .CW        (CW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node_eff (node_eff),
        .i_cmd      (cmd_ch),
        .o_cmd_pop  (cmd_pop),
        .o_res      (res),
        .i_res_full (res_full)
    );

    // result queue
    gbt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_out)
    );

`ifndef SYNTHESIS
    // no result transfer into a full result queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) res.valid |-> !res_full)
        else $error("result written into full queue");

    // command taken only when one waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd_pop |-> cmd_ch.valid)
        else $error("command popped from empty queue");

    // result side is empty right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present after reset");
`endif

endmodule
